>>> hdl/gha_pkg.sv
// Package for the generational handle allocator.
// Holds the port field widths, parameter defaults and the opcode, status and state types.
// Depends on nothing.
package gha_pkg;

  localparam int GHA_NUM_SLOTS = 1024;
  localparam int GHA_GEN_BITS  = 16;
  localparam int GHA_MASK_BITS = 32;

  localparam int OPCODE_W   = 3;
  localparam int SLOT_IN_W  = 12;
  localparam int GEN_IN_W   = 16;
  localparam int MASK_IN_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 10;
  localparam int LIVE_W     = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE    = 3'd0,
    OP_DESTROY   = 3'd1,
    OP_CHECK     = 3'd2,
    OP_GET_MASK  = 3'd3,
    OP_SET_MASK  = 3'd4,
    OP_CLEAR_ALL = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_DEAD    = 2'd2,
    STAT_RANGE   = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    S_SWEEP = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_e;

endpackage

>>> hdl/gha_ram.sv
// Simple dual-port synchronous RAM for the handle allocator.
// One write port and one registered read port; used for the slot table and the free stack.
// Depends on nothing.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/generational_handle_allocator.sv
// Each item is accepted in the idle state, which issues the reads of the slot table and of the
// free stack, and is then executed in the execute state, which writes the memories back as its
// opcode requires and loads the result register. No new item is accepted until the last one has
// been executed, and the next is accepted at the earliest in the cycle after execution; a stalled
// result register holds execution. After reset and after each clear all, a clearing sweep over all
// NUM_SLOTS entries (1024 by default) rebuilds the slot table and the free stack, and no item is accepted meanwhile.
//
// Top level of the generational handle allocator: control sequencer and result register.
// Depends on gha_pkg and gha_ram.
module generational_handle_allocator #(
  parameter int NUM_SLOTS = gha_pkg::GHA_NUM_SLOTS,
  parameter int GEN_BITS  = gha_pkg::GHA_GEN_BITS,
  parameter int MASK_BITS = gha_pkg::GHA_MASK_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gha_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [gha_pkg::SLOT_IN_W-1:0]   slot_index_i,
  input  logic [gha_pkg::GEN_IN_W-1:0]    handle_generation_i,
  input  logic [gha_pkg::MASK_IN_W-1:0]   mask_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gha_pkg::STATUS_W-1:0]    status_o,
  output logic [gha_pkg::SLOT_OUT_W-1:0]  slot_out_o,
  output logic [gha_pkg::GEN_IN_W-1:0]    generation_out_o,
  output logic                            is_alive_o,
  output logic [gha_pkg::MASK_IN_W-1:0]   mask_out_o,
  output logic [gha_pkg::LIVE_W-1:0]      live_count_o
);
  import gha_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int TW = $clog2(NUM_SLOTS + 1);
  localparam int SW = AW + GEN_BITS;
  localparam int EW = 1 + GEN_BITS + MASK_BITS;
  localparam int CW = (GEN_BITS > GEN_IN_W) ? GEN_BITS : GEN_IN_W;

  state_e state_q, state_d;
  logic [AW-1:0] sweep_cnt_q, sweep_cnt_d;
  logic [TW-1:0] top_q, top_d;
  logic [TW-1:0] live_q, live_d;

  op_e                  op_q;
  logic [SLOT_IN_W-1:0] idx_q;
  logic [GEN_IN_W-1:0]  hgen_q;
  logic [MASK_IN_W-1:0] min_q;

  logic                  out_valid_q;
  stat_e                 status_q;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic [GEN_IN_W-1:0]   gen_q;
  logic                  alive_q;
  logic [MASK_IN_W-1:0]  mask_q;
  logic [LIVE_W-1:0]     live_out_q;

  logic          accept;
  logic          out_free;
  logic          exec_go;
  logic [AW-1:0] idx_a;
  logic          in_range;

  logic          slot_we;
  logic [AW-1:0] slot_waddr;
  logic [EW-1:0] slot_wdata;
  logic [EW-1:0] slot_rdata;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [SW-1:0] stk_wdata;
  logic [SW-1:0] stk_rdata;
  logic [AW-1:0] stk_raddr;

  logic                 s_alive;
  logic [GEN_BITS-1:0]  s_gen;
  logic [MASK_BITS-1:0] s_mask;
  logic [AW-1:0]        k_slot;
  logic [GEN_BITS-1:0]  k_gen;
  logic                 match;
  logic [GEN_BITS-1:0]  gen_inc;
  logic [MASK_BITS-1:0] mask_new;

  stat_e                 r_status;
  logic [SLOT_OUT_W-1:0] r_slot;
  logic [GEN_BITS-1:0]   r_gen;
  logic                  r_alive;
  logic [MASK_BITS-1:0]  r_mask;

  assign accept     = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec_go    = (state_q == S_EXEC) && out_free;
  assign idx_a      = idx_q[AW-1:0];
  assign in_range   = {1'b0, idx_q} < (SLOT_IN_W + 1)'(NUM_SLOTS);
  assign stk_raddr  = AW'(top_q - TW'(1));

  assign s_alive  = slot_rdata[EW-1];
  assign s_gen    = slot_rdata[EW-2 -: GEN_BITS];
  assign s_mask   = slot_rdata[MASK_BITS-1:0];
  assign k_slot   = stk_rdata[SW-1 -: AW];
  assign k_gen    = stk_rdata[GEN_BITS-1:0];
  assign match    = s_alive && (CW'(s_gen) == CW'(hgen_q));
  assign gen_inc  = s_gen + GEN_BITS'(1);
  assign mask_new = MASK_BITS'(min_q);

  gha_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .re_i   (accept),
    .raddr_i(slot_index_i[AW-1:0]),
    .rdata_o(slot_rdata)
  );

  gha_ram #(
    .WIDTH(SW),
    .DEPTH(NUM_SLOTS)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (accept),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_SWEEP: begin
        if (sweep_cnt_q == AW'(NUM_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = (op_q == OP_CLEAR_ALL) ? S_SWEEP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    top_d       = top_q;
    live_d      = live_q;
    sweep_cnt_d = sweep_cnt_q;
    slot_we     = 1'b0;
    slot_waddr  = idx_a;
    slot_wdata  = {s_alive, s_gen, s_mask};
    stk_we      = 1'b0;
    stk_waddr   = AW'(top_q);
    stk_wdata   = {idx_a, gen_inc};
    r_status    = STAT_OK;
    r_slot      = idx_q[SLOT_OUT_W-1:0];
    r_gen       = '0;
    r_alive     = 1'b0;
    r_mask      = '0;
    case (state_q)
      S_SWEEP: begin
        slot_we     = 1'b1;
        slot_waddr  = sweep_cnt_q;
        slot_wdata  = '0;
        stk_we      = 1'b1;
        stk_waddr   = sweep_cnt_q;
        stk_wdata   = {AW'(NUM_SLOTS - 1) - sweep_cnt_q, GEN_BITS'(0)};
        sweep_cnt_d = (sweep_cnt_q == AW'(NUM_SLOTS - 1)) ? '0 : sweep_cnt_q + AW'(1);
      end
      S_EXEC: begin
        if (out_free) begin
          case (op_q)
            OP_CREATE: begin
              if (top_q == '0) begin
                r_status = STAT_NO_FREE;
              end else begin
                top_d      = top_q - TW'(1);
                live_d     = live_q + TW'(1);
                slot_we    = 1'b1;
                slot_waddr = k_slot;
                slot_wdata = {1'b1, k_gen, MASK_BITS'(0)};
                r_slot     = SLOT_OUT_W'(k_slot);
                r_gen      = k_gen;
                r_alive    = 1'b1;
              end
            end
            OP_DESTROY: begin
              if (!in_range) begin
                r_status = STAT_RANGE;
              end else if (!match) begin
                r_status = STAT_DEAD;
                r_gen    = s_gen;
              end else begin
                slot_we    = 1'b1;
                slot_wdata = {1'b0, gen_inc, s_mask};
                if (top_q < TW'(NUM_SLOTS)) begin
                  stk_we = 1'b1;
                  top_d  = top_q + TW'(1);
                end
                if (live_q != '0) begin
                  live_d = live_q - TW'(1);
                end
                r_gen = gen_inc;
              end
            end
            OP_CHECK, OP_GET_MASK, OP_SET_MASK: begin
              if (!in_range) begin
                r_status = STAT_RANGE;
              end else begin
                r_gen   = s_gen;
                r_alive = match;
                if (op_q == OP_SET_MASK) begin
                  slot_we    = 1'b1;
                  slot_wdata = {s_alive, s_gen, mask_new};
                  r_mask     = mask_new;
                end else if (op_q == OP_GET_MASK) begin
                  r_mask = s_mask;
                end
              end
            end
            OP_CLEAR_ALL: begin
              top_d       = TW'(NUM_SLOTS);
              live_d      = '0;
              sweep_cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_cnt_q <= '0;
      top_q       <= TW'(NUM_SLOTS);
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
      top_q       <= top_d;
      live_q      <= live_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(opcode_i);
      idx_q  <= slot_index_i;
      hgen_q <= handle_generation_i;
      min_q  <= mask_in_i;
    end
    if (exec_go) begin
      status_q   <= r_status;
      slot_q     <= r_slot;
      gen_q      <= GEN_IN_W'(r_gen);
      alive_q    <= r_alive;
      mask_q     <= MASK_IN_W'(r_mask);
      live_out_q <= LIVE_W'(live_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_out_o       = slot_q;
  assign generation_out_o = gen_q;
  assign is_alive_o       = alive_q;
  assign mask_out_o       = mask_q;
  assign live_count_o     = live_out_q;

`ifndef SYNTHESIS
  a_count_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((TW + 1)'(live_q) + (TW + 1)'(top_q)) == (TW + 1)'(NUM_SLOTS))
    else $error("Live count and free stack depth do not add up to the table size.");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("A result appeared without an execute cycle.");

  a_sweep_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SWEEP) |-> (sweep_cnt_q == '0))
    else $error("Sweep counter is not at zero outside a clearing sweep.");
`endif

endmodule
